// ===== hdl/uvs_pkg.sv =====
// shared types, constants and functions of the uv sphere vertex generator
`timescale 1ns / 1ps
`default_nettype none
package uvs_pkg;

  localparam int IDX_W    = 9;   // row and column index width
  localparam int SEG_W    = 9;   // segment count register width
  localparam int RAD_W    = 16;  // radius register width
  localparam int CFG_W    = 16;  // configuration write data width
  localparam int NRM_W    = 16;  // normal width, signed q1.14
  localparam int POS_W    = 17;  // position width, signed q8.8
  localparam int TEX_W    = 17;  // texture coordinate width, q1.16
  localparam int QUO_W    = 17;  // quotient bits produced by the divider chain
  localparam int TEX_SH   = 16;  // texture coordinates are scaled by 2^16
  localparam int TRIG_W   = 31;  // first quadrant sine or cosine, q30, 0..2^30

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // rounded up reciprocals of the series divisors, exact for dividends below 2^32
  localparam int RCP_SH = 40;
  localparam logic [63:0] SIN_RCP [1:6] = '{
    ((64'd1 << RCP_SH) + 64'd5) / 64'd6,
    ((64'd1 << RCP_SH) + 64'd19) / 64'd20,
    ((64'd1 << RCP_SH) + 64'd41) / 64'd42,
    ((64'd1 << RCP_SH) + 64'd71) / 64'd72,
    ((64'd1 << RCP_SH) + 64'd109) / 64'd110,
    ((64'd1 << RCP_SH) + 64'd155) / 64'd156
  };
  localparam logic [63:0] COS_RCP [1:7] = '{
    ((64'd1 << RCP_SH) + 64'd1) / 64'd2,
    ((64'd1 << RCP_SH) + 64'd11) / 64'd12,
    ((64'd1 << RCP_SH) + 64'd29) / 64'd30,
    ((64'd1 << RCP_SH) + 64'd55) / 64'd56,
    ((64'd1 << RCP_SH) + 64'd89) / 64'd90,
    ((64'd1 << RCP_SH) + 64'd131) / 64'd132,
    ((64'd1 << RCP_SH) + 64'd181) / 64'd182
  };

  typedef enum logic [0:0] {
    REG_SEGMENT_COUNT = 1'b0,
    REG_SPHERE_RADIUS = 1'b1
  } reg_index_t;

  // first quadrant sine or cosine in q30 by taylor series, evaluated at elaboration only
  function automatic logic [TRIG_W-1:0] quarter_trig(input logic [63:0] r, input int ab,
                                                     input bit want_cos);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [127:0] t;
    int k;
    x  = (r * PI_Q30 + (64'd1 << (ab - 2))) >> (ab - 1);
    x2 = (x * x + (64'd1 << 29)) >> 30;
    if (!want_cos) begin
      term = x;
      sum  = x;
      for (k = 1; k <= 6; k++) begin
        t    = 128'((term * x2) >> 30);
        term = 64'((t * 128'(SIN_RCP[k])) >> RCP_SH);
        sum  = k[0] ? sum - term : sum + term;
      end
    end else begin
      term = ONE_Q30;
      sum  = ONE_Q30;
      for (k = 1; k <= 7; k++) begin
        t    = 128'((term * x2) >> 30);
        term = 64'((t * 128'(COS_RCP[k])) >> RCP_SH);
        sum  = k[0] ? sum - term : sum + term;
      end
    end
    if (sum[63]) sum = 64'd0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum[TRIG_W-1:0];
  endfunction

  // round v / 2^sh to nearest, half away from zero
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v, input int sh);
    logic neg;
    logic [63:0] m;
    neg = v[63];
    m   = neg ? 64'(-v) : 64'(v);
    m   = (m + (64'd1 << (sh - 1))) >> sh;
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/uvs_if.sv =====
// valid/ready channel interfaces for grid points and vertices
`timescale 1ns / 1ps
`default_nettype none
interface uvs_grid_if;
  logic                          valid;
  logic                          ready;
  logic [uvs_pkg::IDX_W-1:0]     row_index;
  logic [uvs_pkg::IDX_W-1:0]     col_index;
  modport source (output valid, output row_index, output col_index, input ready);
  modport sink   (input valid, input row_index, input col_index, output ready);
endinterface

interface uvs_vertex_if;
  logic                             valid;
  logic                             ready;
  logic signed [uvs_pkg::NRM_W-1:0] normal_x;
  logic signed [uvs_pkg::NRM_W-1:0] normal_y;
  logic signed [uvs_pkg::NRM_W-1:0] normal_z;
  logic signed [uvs_pkg::POS_W-1:0] pos_x;
  logic signed [uvs_pkg::POS_W-1:0] pos_y;
  logic signed [uvs_pkg::POS_W-1:0] pos_z;
  logic [uvs_pkg::TEX_W-1:0]        tex_u;
  logic [uvs_pkg::TEX_W-1:0]        tex_v;
  modport source (output valid, output normal_x, output normal_y, output normal_z,
                  output pos_x, output pos_y, output pos_z, output tex_u, output tex_v,
                  input ready);
  modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                  input pos_x, input pos_y, input pos_z, input tex_u, input tex_v,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/uv_sphere_vertex_generator.sv =====
// top level of the uv sphere vertex generator
`timescale 1ns / 1ps
`default_nettype none
// Takes one grid point (row, column) per item and returns one vertex per item: unit normal
// in q1.14, position (normal times radius) in q8.8 and texture coordinates in q1.16, for a
// sphere of segment_count segments. One item is accepted per clock while the output is not
// stalled. The pipe is a chain of 17 divider cells (one quotient bit per cell for the
// four divisions by the segment count) followed by six stages: angle registers, sine/cosine
// table read, normal products, normal rounding, radius products and position rounding.
// Ready propagates back through empty stages, so a stalled output does not stop the front of
// the pipe until it has filled. After reset the sine and cosine tables are loaded in a pass over
// all 2^(ANGLE_BITS-2) entries (1024 at the default), during which no item is accepted;
// configuration writes are taken at any time and must only be made while the block is idle.
module uv_sphere_vertex_generator #(
  parameter int MAX_SEGMENTS = 256,
  parameter int ANGLE_BITS   = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [uvs_pkg::CFG_W-1:0]  cfg_data,
  uvs_grid_if.sink                        grid,
  uvs_vertex_if.source                    vertex
);
  localparam int NB     = $clog2(MAX_SEGMENTS + 1);  // effective segment count width
  localparam int RW     = NB + 1;                    // divider remainder width
  localparam int DW     = NB + uvs_pkg::TEX_SH;      // dividend width
  localparam int QW     = uvs_pkg::QUO_W;
  localparam int LANES  = 4;                         // theta, phi, u, v
  localparam int S      = QW + 6;                    // pipeline stages
  localparam int AW     = ANGLE_BITS - 2;            // quarter turn table address width
  localparam int QN     = 1 << AW;
  localparam int TW     = uvs_pkg::TRIG_W;
  localparam int SA     = QW;                        // angle registers
  localparam int SB     = QW + 1;                    // table read
  localparam int SC     = QW + 2;                    // normal products
  localparam int SD     = QW + 3;                    // rounded normals
  localparam int SE     = QW + 4;                    // radius products
  localparam int SF     = QW + 5;                    // output register

  typedef logic [TW-1:0] tab_t [QN];

  function automatic tab_t make_tab(input bit want_cos);
    tab_t t;
    for (int i = 0; i < QN; i++) begin
      t[i] = uvs_pkg::quarter_trig(64'(i), ANGLE_BITS, want_cos);
    end
    return t;
  endfunction

  localparam tab_t SIN_TAB = make_tab(1'b0);
  localparam tab_t COS_TAB = make_tab(1'b1);

  // configuration registers
  logic [uvs_pkg::SEG_W-1:0] segment_count;
  logic [uvs_pkg::RAD_W-1:0] sphere_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= uvs_pkg::SEG_W'(16);
      sphere_radius <= uvs_pkg::RAD_W'(256);
    end else if (cfg_write) begin
      unique case (uvs_pkg::reg_index_t'(cfg_index))
        uvs_pkg::REG_SEGMENT_COUNT: segment_count <= cfg_data[uvs_pkg::SEG_W-1:0];
        uvs_pkg::REG_SPHERE_RADIUS: sphere_radius <= cfg_data[uvs_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // effective segment count, clamped to 2..MAX_SEGMENTS
  logic [NB-1:0] n_eff;
  always_comb begin
    if (int'(segment_count) < 2) begin
      n_eff = NB'(2);
    end else if (int'(segment_count) > MAX_SEGMENTS) begin
      n_eff = NB'(MAX_SEGMENTS);
    end else begin
      n_eff = NB'(segment_count);
    end
  end

  // table load pass after reset
  logic          fill_busy;
  logic [AW-1:0] fill_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_busy <= 1'b1;
      fill_addr <= '0;
    end else if (fill_busy) begin
      fill_addr <= fill_addr + AW'(1);
      if (fill_addr == AW'(QN - 1)) begin
        fill_busy <= 1'b0;
      end
    end
  end

  // stage valid bits and per stage advance, ready flows back through bubbles
  logic [S-1:0] v;
  logic [S-1:0] en;

  always_comb begin
    en[S-1] = !v[S-1] || vertex.ready;
    for (int i = S - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign grid.ready = en[0] && !fill_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= grid.valid && !fill_busy;
      end
      for (int i = 1; i < S; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // saturate row and column, form the four rounded dividends
  logic [NB-1:0] row_c;
  logic [NB-1:0] col_c;
  logic [DW-1:0] dividend [LANES];

  always_comb begin
    row_c = (int'(grid.row_index) > int'(n_eff)) ? n_eff : NB'(grid.row_index);
    col_c = (int'(grid.col_index) > int'(n_eff)) ? n_eff : NB'(grid.col_index);
    dividend[0] = (DW'(col_c) << ANGLE_BITS) + DW'(n_eff >> 1);
    dividend[1] = (DW'(row_c) << (ANGLE_BITS - 1)) + DW'(n_eff >> 1);
    dividend[2] = (DW'(col_c) << uvs_pkg::TEX_SH) + DW'(n_eff >> 1);
    dividend[3] = (DW'(row_c) << uvs_pkg::TEX_SH) + DW'(n_eff >> 1);
  end

  // divider chain: the upper dividend bits are already below n, then one bit per cell
  logic [RW-1:0] rem_w [QW+1][LANES];
  logic [QW-1:0] sh_w  [QW+1][LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane_in
    assign rem_w[0][l] = RW'(dividend[l] >> QW);
    assign sh_w[0][l]  = dividend[l][QW-1:0];
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      uvs_div_cell #(
        .REM_W (RW),
        .Q_W   (QW)
      ) u_cell (
        .clk     (clk),
        .en      (en[k]),
        .divisor (n_eff),
        .rem_in  (rem_w[k][l]),
        .sh_in   (sh_w[k][l]),
        .rem_out (rem_w[k+1][l]),
        .sh_out  (sh_w[k+1][l])
      );
    end
  end

  // stage a: angles modulo a full turn, texture coordinates
  logic [ANGLE_BITS-1:0]     th_a;
  logic [ANGLE_BITS-1:0]     ph_a;
  logic [uvs_pkg::TEX_W-1:0] u_a;
  logic [uvs_pkg::TEX_W-1:0] v_a;

  always_ff @(posedge clk) begin
    if (en[SA]) begin
      th_a <= sh_w[QW][0][ANGLE_BITS-1:0];
      ph_a <= sh_w[QW][1][ANGLE_BITS-1:0];
      u_a  <= uvs_pkg::TEX_W'(sh_w[QW][2]);
      v_a  <= uvs_pkg::TEX_W'((uvs_pkg::TEX_W'(1) << uvs_pkg::TEX_SH) -
                              uvs_pkg::TEX_W'(sh_w[QW][3]));
    end
  end

  // stage b: quarter turn table read
  logic [TW-1:0]             sin_th;
  logic [TW-1:0]             sin_ph;
  logic [TW-1:0]             cos_th;
  logic [TW-1:0]             cos_ph;
  logic [1:0]                thq_b;
  logic [1:0]                phq_b;
  logic [uvs_pkg::TEX_W-1:0] u_b;
  logic [uvs_pkg::TEX_W-1:0] v_b;

  uvs_ram #(.WIDTH(TW), .DEPTH(QN)) u_sin_ram (
    .clk     (clk),
    .we      (fill_busy),
    .waddr   (fill_addr),
    .wdata   (SIN_TAB[fill_addr]),
    .re      (en[SB]),
    .raddr_a (th_a[AW-1:0]),
    .raddr_b (ph_a[AW-1:0]),
    .rdata_a (sin_th),
    .rdata_b (sin_ph)
  );

  uvs_ram #(.WIDTH(TW), .DEPTH(QN)) u_cos_ram (
    .clk     (clk),
    .we      (fill_busy),
    .waddr   (fill_addr),
    .wdata   (COS_TAB[fill_addr]),
    .re      (en[SB]),
    .raddr_a (th_a[AW-1:0]),
    .raddr_b (ph_a[AW-1:0]),
    .rdata_a (cos_th),
    .rdata_b (cos_ph)
  );

  always_ff @(posedge clk) begin
    if (en[SB]) begin
      thq_b <= th_a[ANGLE_BITS-1:ANGLE_BITS-2];
      phq_b <= ph_a[ANGLE_BITS-1:ANGLE_BITS-2];
      u_b   <= u_a;
      v_b   <= v_a;
    end
  end

  // quadrant unfolding of the first quadrant values
  logic signed [31:0] sth;
  logic signed [31:0] cth;
  logic signed [31:0] sph;
  logic signed [31:0] cph;

  always_comb begin
    logic signed [31:0] s0t;
    logic signed [31:0] c0t;
    logic signed [31:0] s0p;
    logic signed [31:0] c0p;
    s0t = $signed({1'b0, sin_th});
    c0t = $signed({1'b0, cos_th});
    s0p = $signed({1'b0, sin_ph});
    c0p = $signed({1'b0, cos_ph});
    case (thq_b)
      2'd0:    begin sth = s0t;  cth = c0t;  end
      2'd1:    begin sth = c0t;  cth = -s0t; end
      2'd2:    begin sth = -s0t; cth = -c0t; end
      default: begin sth = -c0t; cth = s0t;  end
    endcase
    case (phq_b)
      2'd0:    begin sph = s0p;  cph = c0p;  end
      2'd1:    begin sph = c0p;  cph = -s0p; end
      2'd2:    begin sph = -s0p; cph = -c0p; end
      default: begin sph = -c0p; cph = s0p;  end
    endcase
  end

  // stage c: q60 normal products and the rounded y normal
  logic signed [63:0]               prod_x;
  logic signed [63:0]               prod_z;
  logic signed [uvs_pkg::NRM_W-1:0] ny_c;
  logic [uvs_pkg::TEX_W-1:0]        u_c;
  logic [uvs_pkg::TEX_W-1:0]        v_c;

  always_ff @(posedge clk) begin
    if (en[SC]) begin
      prod_x <= cth * sph;
      prod_z <= sth * sph;
      ny_c   <= uvs_pkg::NRM_W'(uvs_pkg::round_shift(64'(cph), 16));
      u_c    <= u_b;
      v_c    <= v_b;
    end
  end

  // stage d: rounded normals
  logic signed [uvs_pkg::NRM_W-1:0] nx_d;
  logic signed [uvs_pkg::NRM_W-1:0] ny_d;
  logic signed [uvs_pkg::NRM_W-1:0] nz_d;
  logic [uvs_pkg::TEX_W-1:0]        u_d;
  logic [uvs_pkg::TEX_W-1:0]        v_d;

  always_ff @(posedge clk) begin
    if (en[SD]) begin
      nx_d <= uvs_pkg::NRM_W'(uvs_pkg::round_shift(prod_x, 46));
      nz_d <= uvs_pkg::NRM_W'(uvs_pkg::round_shift(prod_z, 46));
      ny_d <= ny_c;
      u_d  <= u_c;
      v_d  <= v_c;
    end
  end

  // stage e: normal times radius
  logic signed [uvs_pkg::RAD_W:0]         rad_s;
  logic signed [uvs_pkg::NRM_W+uvs_pkg::RAD_W:0] px_e;
  logic signed [uvs_pkg::NRM_W+uvs_pkg::RAD_W:0] py_e;
  logic signed [uvs_pkg::NRM_W+uvs_pkg::RAD_W:0] pz_e;
  logic signed [uvs_pkg::NRM_W-1:0]       nx_e;
  logic signed [uvs_pkg::NRM_W-1:0]       ny_e;
  logic signed [uvs_pkg::NRM_W-1:0]       nz_e;
  logic [uvs_pkg::TEX_W-1:0]              u_e;
  logic [uvs_pkg::TEX_W-1:0]              v_e;

  assign rad_s = $signed({1'b0, sphere_radius});

  always_ff @(posedge clk) begin
    if (en[SE]) begin
      px_e <= nx_d * rad_s;
      py_e <= ny_d * rad_s;
      pz_e <= nz_d * rad_s;
      nx_e <= nx_d;
      ny_e <= ny_d;
      nz_e <= nz_d;
      u_e  <= u_d;
      v_e  <= v_d;
    end
  end

  // stage f: output register
  always_ff @(posedge clk) begin
    if (en[SF]) begin
      vertex.pos_x    <= uvs_pkg::POS_W'(uvs_pkg::round_shift(64'(px_e), 14));
      vertex.pos_y    <= uvs_pkg::POS_W'(uvs_pkg::round_shift(64'(py_e), 14));
      vertex.pos_z    <= uvs_pkg::POS_W'(uvs_pkg::round_shift(64'(pz_e), 14));
      vertex.normal_x <= nx_e;
      vertex.normal_y <= ny_e;
      vertex.normal_z <= nz_e;
      vertex.tex_u    <= u_e;
      vertex.tex_v    <= v_e;
    end
  end

  assign vertex.valid = v[SF];

endmodule
`default_nettype wire

// ===== hdl/uvs_ram.sv =====
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps
`default_nettype none
module uvs_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/uvs_div_cell.sv =====
// one restoring division step: shifts in a dividend bit and yields a quotient bit
`timescale 1ns / 1ps
`default_nettype none
module uvs_div_cell #(
  parameter int REM_W = 10,
  parameter int Q_W   = 17
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [REM_W-2:0] divisor,
  input  wire logic [REM_W-1:0] rem_in,
  input  wire logic [Q_W-1:0]   sh_in,
  output logic      [REM_W-1:0] rem_out,
  output logic      [Q_W-1:0]   sh_out
);
  logic [REM_W-1:0] trial;
  logic             ge;

  assign trial = {rem_in[REM_W-2:0], sh_in[Q_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? trial - {1'b0, divisor} : trial;
      sh_out  <= {sh_in[Q_W-2:0], ge};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/uvs_checker.sv =====
// port level assertions for the uv sphere vertex generator and their bind
`timescale 1ns / 1ps
`default_nettype none
module uvs_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [uvs_pkg::NRM_W-1:0]  normal_y,
  input wire logic [uvs_pkg::TEX_W-1:0]         tex_u,
  input wire logic [uvs_pkg::TEX_W-1:0]         tex_v
);
  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("vertex valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled vertex dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(tex_u) && $stable(tex_v) && $stable(normal_y))
    else $error("stalled vertex changed");

  // texture coordinates never pass one
  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tex_u <= 17'd65536) && (tex_v <= 17'd65536))
    else $error("texture coordinate out of range");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (normal_y <= 16'sd16384) && (normal_y >= -16'sd16384))
    else $error("normal y out of range");
endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (vertex.valid),
  .out_ready (vertex.ready),
  .normal_y  (vertex.normal_y),
  .tex_u     (vertex.tex_u),
  .tex_v     (vertex.tex_v)
);
`default_nettype wire

// ===== sim/uv_sphere_vertex_generator_tb.sv =====
// self-checking testbench of the uv sphere vertex generator
`timescale 1ns / 1ps
module uv_sphere_vertex_generator_tb;

  localparam int ABITS      = 12;          // angle resolution of the block
  localparam int SEG_MAX    = 256;         // largest effective segment count
  localparam int PIPE_DEPTH = 23;          // pipeline stages of the block
  localparam logic [63:0] PI_FIX  = 64'd3373259426;   // pi in q30
  localparam logic [63:0] UNIT_FIX = 64'd1073741824;  // 1.0 in q30

  typedef struct {
    logic signed [uvs_pkg::NRM_W-1:0] nx, ny, nz;
    logic signed [uvs_pkg::POS_W-1:0] px, py, pz;
    logic [uvs_pkg::TEX_W-1:0]        u, v;
  } vertex_t;

  // holds the register copy and the vertices still owed by the block
  class vertex_scoreboard;
    logic [uvs_pkg::SEG_W-1:0] seg_count = 16;
    logic [uvs_pkg::RAD_W-1:0] radius    = 256;
    vertex_t          owed[$];
    int               errors    = 0;
    int               checked   = 0;

    // first quadrant sine and cosine in q30 by a truncated series
    function void quadrant_sin_cos(input logic [63:0] r, output logic [63:0] s,
                                   output logic [63:0] c);
      logic [63:0] x, x2, term, acc;
      int k;
      x  = (r * PI_FIX + (64'd1 << (ABITS - 2))) >> (ABITS - 1);
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      acc  = x;
      for (k = 1; k <= 6; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        acc  = (k % 2 == 1) ? acc - term : acc + term;
      end
      if (acc[63]) acc = 0;
      if (acc > UNIT_FIX) acc = UNIT_FIX;
      s = acc;
      term = UNIT_FIX;
      acc  = UNIT_FIX;
      for (k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
        acc  = (k % 2 == 1) ? acc - term : acc + term;
      end
      if (acc[63]) acc = 0;
      if (acc > UNIT_FIX) acc = UNIT_FIX;
      c = acc;
    endfunction

    // signed sine and cosine of an angle in units of a 2^ABITS part of a turn
    function void turn_sin_cos(input logic [63:0] ang, output logic signed [63:0] s,
                               output logic signed [63:0] c);
      logic [63:0] s0, c0;
      logic [1:0]  quad;
      quad = ang[ABITS-1 -: 2];
      quadrant_sin_cos(ang & ((64'd1 << (ABITS - 2)) - 1), s0, c0);
      case (quad)
        2'd0: begin s = s0;  c = c0;  end
        2'd1: begin s = c0;  c = -c0 + c0 - s0; end
        2'd2: begin s = -s0; c = -c0; end
        default: begin s = -c0; c = s0; end
      endcase
    endfunction

    // divide by 2^sh, nearest, ties away from zero
    function logic signed [63:0] round_down_by(input logic signed [63:0] val, input int sh);
      logic [63:0] mag;
      mag = val[63] ? 64'(-val) : 64'(val);
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      return val[63] ? -$signed(mag) : $signed(mag);
    endfunction

    function void note_grid(input logic [uvs_pkg::IDX_W-1:0] row_in,
                            input logic [uvs_pkg::IDX_W-1:0] col_in);
      logic [63:0] n, row, col, th, ph;
      logic signed [63:0] sth, cth, sph, cph, nx, ny, nz, rad;
      vertex_t e;
      n   = seg_count;
      row = row_in;
      col = col_in;
      // out of range segment counts clamp, then the grid point saturates to the count
      if (n < 2) n = 2;
      if (n > SEG_MAX) n = SEG_MAX;
      if (row > n) row = n;
      if (col > n) col = n;
      th = ((col << ABITS) + n / 2) / n;
      ph = ((row << (ABITS - 1)) + n / 2) / n;
      turn_sin_cos(th, sth, cth);
      turn_sin_cos(ph, sph, cph);
      nx  = round_down_by(cth * sph, 46);
      ny  = round_down_by(cph, 16);
      nz  = round_down_by(sth * sph, 46);
      rad = $signed({48'd0, radius});
      e.nx = nx[uvs_pkg::NRM_W-1:0];
      e.ny = ny[uvs_pkg::NRM_W-1:0];
      e.nz = nz[uvs_pkg::NRM_W-1:0];
      e.px = 17'(round_down_by(nx * rad, 14));
      e.py = 17'(round_down_by(ny * rad, 14));
      e.pz = 17'(round_down_by(nz * rad, 14));
      e.u  = 17'(((col << 16) + n / 2) / n);
      e.v  = 17'(64'd65536 - ((row << 16) + n / 2) / n);
      owed = {owed, e};
    endfunction

    function void check_vertex(input vertex_t got);
      vertex_t e;
      if (owed.size() == 0) begin
        $display("%0t: vertex with nothing owed", $time);
        errors++;
        return;
      end
      e = owed.pop_front();
      checked++;
      if (got.nx !== e.nx) begin
        $display("%0t: normal_x exp %0d got %0d", $time, e.nx, got.nx); errors++;
      end
      if (got.ny !== e.ny) begin
        $display("%0t: normal_y exp %0d got %0d", $time, e.ny, got.ny); errors++;
      end
      if (got.nz !== e.nz) begin
        $display("%0t: normal_z exp %0d got %0d", $time, e.nz, got.nz); errors++;
      end
      if (got.px !== e.px) begin
        $display("%0t: pos_x exp %0d got %0d", $time, e.px, got.px); errors++;
      end
      if (got.py !== e.py) begin
        $display("%0t: pos_y exp %0d got %0d", $time, e.py, got.py); errors++;
      end
      if (got.pz !== e.pz) begin
        $display("%0t: pos_z exp %0d got %0d", $time, e.pz, got.pz); errors++;
      end
      if (got.u !== e.u) begin
        $display("%0t: tex_u exp %0d got %0d", $time, e.u, got.u); errors++;
      end
      if (got.v !== e.v) begin
        $display("%0t: tex_v exp %0d got %0d", $time, e.v, got.v); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = uvs_pkg::REG_SEGMENT_COUNT;
  logic [uvs_pkg::CFG_W-1:0] cfg_data = '0;
  bit quiet_sender = 0;     // no gaps from the sender
  bit quiet_receiver = 0;   // no stalls at the receiver
  int sent = 0;

  uvs_grid_if   grid();
  uvs_vertex_if vertex();

  vertex_scoreboard sb = new();

  uv_sphere_vertex_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .grid      (grid.sink),
    .vertex    (vertex.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls about 14 percent of the time unless told to stay quiet
  always @(posedge clk) begin
    if (rst) vertex.ready <= 1'b0;
    else vertex.ready <= quiet_receiver || ($urandom_range(99) >= 14);
  end

  // every accepted grid point is noted, every accepted vertex checked
  always @(posedge clk) begin
    vertex_t got;
    if (!rst && grid.valid && grid.ready) sb.note_grid(grid.row_index, grid.col_index);
    if (!rst && vertex.valid && vertex.ready) begin
      got.nx = vertex.normal_x; got.ny = vertex.normal_y; got.nz = vertex.normal_z;
      got.px = vertex.pos_x;    got.py = vertex.pos_y;    got.pz = vertex.pos_z;
      got.u  = vertex.tex_u;    got.v  = vertex.tex_v;
      sb.check_vertex(got);
    end
  end

  // one grid point, with an occasional gap in front of it
  task automatic send_point(input int row, input int col);
    if (!quiet_sender && $urandom_range(99) < 14) begin
      grid.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    grid.valid     <= 1'b1;
    grid.row_index <= uvs_pkg::IDX_W'(row);
    grid.col_index <= uvs_pkg::IDX_W'(col);
    do @(posedge clk); while (!grid.ready);
    sent++;
  endtask

  // stop sending and let every owed vertex come out
  task automatic drain();
    grid.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
  endtask

  // register write while the pipe is empty; the copy follows at the same edge
  task automatic write_reg(input uvs_pkg::reg_index_t idx, input int val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= uvs_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == uvs_pkg::REG_SEGMENT_COUNT) sb.seg_count = uvs_pkg::SEG_W'(val);
    else sb.radius = uvs_pkg::RAD_W'(val);
    @(posedge clk);
  endtask

  // mostly points on the grid, some beyond the count, a few anywhere in the field
  task automatic random_points(input int count, input int seg);
    int n, row, col, pick;
    n = (seg < 2) ? 2 : (seg > SEG_MAX ? SEG_MAX : seg);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        row = $urandom_range(n);
        col = $urandom_range(n);
      end else if (pick < 90) begin
        row = $urandom_range(511, n);
        col = $urandom_range(n);
      end else begin
        row = $urandom_range(511);
        col = $urandom_range(511);
      end
      send_point(row, col);
    end
  endtask

  function automatic int controlled_count(input int p);
    return 80;
  endfunction

  initial begin
    int seg_list[8];
    int rad_list[8];
    int seg;
    grid.valid     = 1'b0;
    grid.row_index = '0;
    grid.col_index = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values written back explicitly, then the directed corners
    write_reg(uvs_pkg::REG_SEGMENT_COUNT, 16);
    write_reg(uvs_pkg::REG_SPHERE_RADIUS, 256);
    send_point(0, 0);       // top pole
    send_point(16, 0);      // bottom pole
    send_point(8, 0);       // equator
    send_point(8, 4);       // quarter turn
    send_point(8, 8);       // half turn
    send_point(8, 12);      // three quarter turn
    send_point(8, 16);      // closing column wraps theta, u stays at one
    send_point(4, 16);
    send_point(17, 3);      // row past the count saturates
    send_point(5, 17);      // column past the count saturates
    send_point(511, 511);   // all ones
    send_point(256, 256);
    send_point(255, 1);
    send_point(1, 255);
    send_point(3, 5);
    send_point(13, 7);
    drain();

    // extremes of both registers, count values that clamp, and a random pair
    seg_list = '{2, 256, 0, 1, 511, 300, 7, 0};
    rad_list = '{0, 65535, 65535, 1, 12345, 256, 32768, 0};
    seg_list[7] = $urandom_range(511);
    rad_list[7] = $urandom_range(65535);
    for (int p = 0; p < 8; p++) begin
      seg = seg_list[p];
      write_reg(uvs_pkg::REG_SEGMENT_COUNT, seg);
      write_reg(uvs_pkg::REG_SPHERE_RADIUS, rad_list[p]);
      // one long stretch with neither gaps nor stalls
      quiet_sender   = (p == 1);
      quiet_receiver = (p == 1);
      random_points(70, seg);
      if (p == 2) drain();   // sender holds until the pipe is empty
      random_points(controlled_count(p), seg);
      drain();
    end

    $display("checked %0d vertices from %0d grid points over 9 register settings,",
             sb.checked, sent);
    $display("counts 2 to 256 with clamped values, radius 0 to full scale");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
